// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, payload types and control types of the first-fit heap
// allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int ARENA_BYTES = 4096;
   localparam int HDR_BYTES   = 8;
   localparam int MAX_REQUEST = ARENA_BYTES - HDR_BYTES;
   localparam int OFFS_W      = $clog2(ARENA_BYTES);
   localparam int SIZE_W      = OFFS_W + 1;
   localparam int FIELD_W     = 12;
   localparam int STATUS_W    = 3;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 3'd0,
      STAT_BAD_SIZE    = 3'd1,
      STAT_NO_SPACE    = 3'd2,
      STAT_DOUBLE_FREE = 3'd3,
      STAT_BAD_POINTER = 3'd4
   } status_type;

   typedef struct packed {
      logic               mode;
      logic [FIELD_W-1:0] request_size;
      logic [FIELD_W-1:0] payload_offset;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  block_offset;
   } rsp_type;

   typedef struct packed {
      logic              used;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_NEXT,
      S_SPLIT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       start;
      logic       advance;
      logic       read_next;
      logic       wr_alloc;
      logic       wr_rest;
      logic       wr_free;
      logic       finish;
      status_type status;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic bad_size;
      logic walk_end;
      logic fit;
      logic split;
      logic hit;
      logic hit_used;
      logic mode_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/ffha_dpath.sv =====
// ----------------------------------------------------------------------------
// ffha_dpath
// Header store, walk pointer, neighbor tracking and result registers of the
// allocator. Reads one header per cycle and writes at most one per cycle.
// ----------------------------------------------------------------------------
module ffha_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  ffha_pkg::cmd_type     cmd,
   input  ffha_pkg::req_type     req,
   output ffha_pkg::dp_stat_type stat,
   output ffha_pkg::rsp_type     rsp_data
);

   ffha_pkg::hdr_type mem [ffha_pkg::ARENA_BYTES];

   ffha_pkg::hdr_type                 rd_data_ff;
   logic                              rd_zero_ff;
   logic                              hdr0_valid_ff;
   logic [ffha_pkg::OFFS_W-1:0]       pos_ff;
   logic                              pos_end_ff;
   logic                              mode_ff;
   logic [ffha_pkg::SIZE_W-1:0]       need_ff;
   logic [ffha_pkg::SIZE_W-1:0]       poff_ff;
   logic [ffha_pkg::OFFS_W-1:0]       prev_pos_ff;
   ffha_pkg::hdr_type                 prev_hdr_ff;
   logic                              has_prev_ff;
   logic [ffha_pkg::SIZE_W-1:0]       cur_size_ff;
   logic                              nxt_valid_ff;
   ffha_pkg::status_type              res_status_ff;
   logic [ffha_pkg::FIELD_W-1:0]      res_offset_ff;
   ffha_pkg::rsp_type                 rsp_data_ff;

   ffha_pkg::hdr_type                 hdr;
   logic [ffha_pkg::SIZE_W:0]         pos_sum;
   logic [ffha_pkg::OFFS_W-1:0]       rd_addr;
   logic [ffha_pkg::SIZE_W-1:0]       need_req;
   logic [ffha_pkg::SIZE_W-1:0]       pay_pos;
   logic                              next_free;
   logic                              prev_free;
   logic [ffha_pkg::SIZE_W-1:0]       merged;
   logic                              wr_en;
   logic [ffha_pkg::OFFS_W-1:0]       wr_addr;
   ffha_pkg::hdr_type                 wr_data;

   // Entry 0 reads as one free block spanning the arena until first written.
   always_comb begin
      if (rd_zero_ff && !hdr0_valid_ff) begin
         hdr.used = 1'b0;
         hdr.size = ffha_pkg::SIZE_W'(ffha_pkg::ARENA_BYTES);
      end else begin
         hdr = rd_data_ff;
      end
   end

   assign pos_sum  = (ffha_pkg::SIZE_W+1)'(pos_ff) + (ffha_pkg::SIZE_W+1)'(hdr.size);
   assign rd_addr  = cmd.start ? '0 : pos_sum[ffha_pkg::OFFS_W-1:0];
   assign need_req = ffha_pkg::SIZE_W'(req.request_size) + ffha_pkg::SIZE_W'(ffha_pkg::HDR_BYTES);
   assign pay_pos  = ffha_pkg::SIZE_W'(pos_ff) + ffha_pkg::SIZE_W'(ffha_pkg::HDR_BYTES);

   assign stat.bad_size  = (req.mode == ffha_pkg::MODE_ALLOC) &&
                           ((req.request_size == '0) ||
                            (ffha_pkg::SIZE_W'(req.request_size) >=
                             ffha_pkg::SIZE_W'(ffha_pkg::MAX_REQUEST)));
   assign stat.walk_end  = pos_end_ff || (hdr.size == '0);
   assign stat.fit       = !hdr.used &&
                           ((hdr.size == need_ff) ||
                            (hdr.size > need_ff + ffha_pkg::SIZE_W'(ffha_pkg::HDR_BYTES)));
   assign stat.split     = (hdr.size != need_ff);
   assign stat.hit       = (pay_pos == poff_ff);
   assign stat.hit_used  = hdr.used;
   assign stat.mode_free = (mode_ff == ffha_pkg::MODE_FREE);

   // While freeing, the header read last is the right-hand neighbor.
   assign next_free = nxt_valid_ff && !hdr.used;
   assign prev_free = has_prev_ff && !prev_hdr_ff.used;
   assign merged    = cur_size_ff + (next_free ? hdr.size : '0);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = pos_ff;
      wr_data = '0;
      priority if (cmd.wr_alloc) begin
         wr_en        = 1'b1;
         wr_data.used = 1'b1;
         wr_data.size = need_ff;
      end else if (cmd.wr_rest) begin
         wr_en        = 1'b1;
         wr_addr      = ffha_pkg::OFFS_W'(ffha_pkg::SIZE_W'(pos_ff) + need_ff);
         wr_data.size = cur_size_ff - need_ff;
      end else if (cmd.wr_free) begin
         wr_en = 1'b1;
         if (prev_free) begin
            wr_addr      = prev_pos_ff;
            wr_data.size = prev_hdr_ff.size + merged;
         end else begin
            wr_data.size = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr0_valid_ff <= 1'b0;
         rd_zero_ff    <= 1'b0;
      end else begin
         rd_zero_ff <= (rd_addr == '0);
         if (wr_en && wr_addr == '0) begin
            hdr0_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         pos_ff      <= '0;
         pos_end_ff  <= 1'b0;
         mode_ff     <= req.mode;
         need_ff     <= need_req;
         poff_ff     <= ffha_pkg::SIZE_W'(req.payload_offset);
         has_prev_ff <= 1'b0;
      end
      if (cmd.advance) begin
         prev_pos_ff <= pos_ff;
         prev_hdr_ff <= hdr;
         has_prev_ff <= 1'b1;
         pos_ff      <= pos_sum[ffha_pkg::OFFS_W-1:0];
         pos_end_ff  <= (pos_sum >= (ffha_pkg::SIZE_W+1)'(ffha_pkg::ARENA_BYTES));
      end
      if (cmd.wr_alloc || cmd.read_next) begin
         cur_size_ff <= hdr.size;
      end
      if (cmd.read_next) begin
         nxt_valid_ff <= (pos_sum < (ffha_pkg::SIZE_W+1)'(ffha_pkg::ARENA_BYTES));
      end
      if (cmd.finish) begin
         res_status_ff <= cmd.status;
         if (cmd.status == ffha_pkg::STAT_OK && mode_ff == ffha_pkg::MODE_ALLOC) begin
            res_offset_ff <= ffha_pkg::FIELD_W'(pay_pos);
         end else begin
            res_offset_ff <= '0;
         end
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.status       <= res_status_ff;
         rsp_data_ff.block_offset <= res_offset_ff;
      end
   end

   assign rsp_data = rsp_data_ff;

   a_wr_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_data.size != '0)
      else $error("header written with zero size");

   a_rest_after_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_rest |-> $past(cmd.wr_alloc))
      else $error("split remainder written without a preceding allocation write");

   a_rest_large: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_rest |-> wr_data.size > ffha_pkg::SIZE_W'(ffha_pkg::HDR_BYTES))
      else $error("split remainder not larger than a header");

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer of the allocator: starts a walk, decides on each header, issues
// the header writes and hands the result to the output register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ffha_pkg::dp_stat_type stat,
   output ffha_pkg::cmd_type     cmd
);

   ffha_pkg::state_type state_ff;
   ffha_pkg::state_type state_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               if (stat.bad_size) begin
                  cmd.finish = 1'b1;
                  cmd.status = ffha_pkg::STAT_BAD_SIZE;
                  state_in   = ffha_pkg::S_DONE;
               end else begin
                  state_in = ffha_pkg::S_WALK;
               end
            end
         end
         ffha_pkg::S_WALK: begin
            priority if (stat.walk_end) begin
               cmd.finish = 1'b1;
               cmd.status = stat.mode_free ? ffha_pkg::STAT_BAD_POINTER
                                           : ffha_pkg::STAT_NO_SPACE;
               state_in   = ffha_pkg::S_DONE;
            end else if (!stat.mode_free && stat.fit) begin
               cmd.wr_alloc = 1'b1;
               if (stat.split) begin
                  state_in = ffha_pkg::S_SPLIT;
               end else begin
                  cmd.finish = 1'b1;
                  cmd.status = ffha_pkg::STAT_OK;
                  state_in   = ffha_pkg::S_DONE;
               end
            end else if (stat.mode_free && stat.hit) begin
               if (!stat.hit_used) begin
                  cmd.finish = 1'b1;
                  cmd.status = ffha_pkg::STAT_DOUBLE_FREE;
                  state_in   = ffha_pkg::S_DONE;
               end else begin
                  // Fetch the right-hand neighbor before merging.
                  cmd.read_next = 1'b1;
                  state_in      = ffha_pkg::S_NEXT;
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ffha_pkg::S_NEXT: begin
            cmd.wr_free = 1'b1;
            cmd.finish  = 1'b1;
            cmd.status  = ffha_pkg::STAT_OK;
            state_in    = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_SPLIT: begin
            cmd.wr_rest = 1'b1;
            cmd.finish  = 1'b1;
            cmd.status  = ffha_pkg::STAT_OK;
            state_in    = ffha_pkg::S_DONE;
         end
         ffha_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ffha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ffha_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_split_from_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffha_pkg::S_SPLIT |-> $past(state_ff) == ffha_pkg::S_WALK)
      else $error("split step entered from outside the walk");

   a_next_from_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffha_pkg::S_NEXT |-> $past(state_ff) == ffha_pkg::S_WALK)
      else $error("neighbor step entered from outside the walk");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ffha_pkg::S_DONE)
      else $error("response raised without a finished request");

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with coalescing over a 4096-byte arena of blocks, each
// led by an 8-byte header holding the block size and a used mark.
// ----------------------------------------------------------------------------
// A request on req_data either allocates request_size payload bytes (mode 0)
// or frees the block whose payload starts at payload_offset (mode 1). Each
// request yields exactly one response on rsp_data with a status code and, for
// a successful allocation, the payload offset of the new block.
// Both channels use valid/ready. A request is taken only while no other is
// being processed. The walk reads one header per cycle from the header
// store's single read port, starting at offset 0, and visits at most 455
// headers, since no block is smaller than 9 bytes. After the walk, a split
// writes the remainder header and a free writes the merged header in a
// further step; a rejected size goes straight to the response. The next
// request can be taken in the cycle its predecessor's response is
// offered. The response sits in an output register; a new request is taken
// while it waits, and a stalled receiver holds only the next finished result
// back. Reset restores one free block spanning the whole arena; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffha_pkg::rsp_type rsp_data
);

   ffha_pkg::cmd_type     cmd;
   ffha_pkg::dp_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffha_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req      (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the first-fit heap allocator. A directed set of
// requests covers rejected sizes, unknown and already freed pointers, exact
// fits, merges with both neighbors and the blocks at the arena edges. A long
// random run of allocate and free traffic follows. A predictor keeps its own
// copy of the header chain and queues the expected response of every accepted
// request, and each response is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int SETTLE_CYCLES = 600;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   ffha_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ffha_pkg::rsp_type rsp_data;

   // Predicted header chain, indexed by block start offset.
   logic [ffha_pkg::SIZE_W-1:0] blk_size [0:ffha_pkg::ARENA_BYTES-1];
   logic                        blk_used [0:ffha_pkg::ARENA_BYTES-1];

   ffha_pkg::rsp_type expected_rsp [$];
   int unsigned       live_offsets [$];
   int unsigned       freed_offsets [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                idle_on = 1'b1;

   first_fit_heap_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic ffha_pkg::status_type heap_allocate(input int unsigned bytes,
                                                          output int unsigned payload);
      int unsigned need;
      int unsigned pos;
      int unsigned bsz;
      payload = 0;
      if (bytes < 1 || bytes >= ffha_pkg::MAX_REQUEST) return ffha_pkg::STAT_BAD_SIZE;
      need = bytes + ffha_pkg::HDR_BYTES;
      pos = 0;
      while (pos < ffha_pkg::ARENA_BYTES) begin
         bsz = 32'(blk_size[pos]);
         if (bsz == 0) break;
         // A split is only taken when the remainder can hold a header and data.
         if (!blk_used[pos] &&
             (bsz == need || (bsz > need && bsz - need > ffha_pkg::HDR_BYTES))) begin
            blk_used[pos] = 1'b1;
            blk_size[pos] = ffha_pkg::SIZE_W'(need);
            if (bsz != need) begin
               blk_size[pos + need] = ffha_pkg::SIZE_W'(bsz - need);
               blk_used[pos + need] = 1'b0;
            end
            payload = pos + ffha_pkg::HDR_BYTES;
            return ffha_pkg::STAT_OK;
         end
         pos += bsz;
      end
      return ffha_pkg::STAT_NO_SPACE;
   endfunction

   function automatic ffha_pkg::status_type heap_release(input int unsigned poff);
      int unsigned pos;
      int unsigned prev;
      int unsigned bsz;
      int unsigned nxt;
      bit          has_prev;
      bit          prev_free;
      bit          next_free;
      pos = 0;
      prev = 0;
      has_prev = 1'b0;
      while (pos < ffha_pkg::ARENA_BYTES) begin
         bsz = 32'(blk_size[pos]);
         if (bsz == 0) break;
         if (poff == pos + ffha_pkg::HDR_BYTES) begin
            if (!blk_used[pos]) return ffha_pkg::STAT_DOUBLE_FREE;
            nxt = pos + bsz;
            prev_free = has_prev && !blk_used[prev];
            next_free = (nxt < ffha_pkg::ARENA_BYTES) && !blk_used[nxt];
            blk_used[pos] = 1'b0;
            if (next_free) blk_size[pos] = ffha_pkg::SIZE_W'(bsz + 32'(blk_size[nxt]));
            if (prev_free) blk_size[prev] = blk_size[prev] + blk_size[pos];
            return ffha_pkg::STAT_OK;
         end
         prev = pos;
         has_prev = 1'b1;
         pos += bsz;
      end
      return ffha_pkg::STAT_BAD_POINTER;
   endfunction

   function automatic ffha_pkg::rsp_type heap_apply(input ffha_pkg::req_type r);
      ffha_pkg::rsp_type res;
      int unsigned       payload;
      if (r.mode == ffha_pkg::MODE_ALLOC) begin
         res.status = heap_allocate(32'(r.request_size), payload);
         res.block_offset = (res.status == ffha_pkg::STAT_OK) ?
                            payload[ffha_pkg::FIELD_W-1:0] : '0;
      end else begin
         res.status = heap_release(32'(r.payload_offset));
         res.block_offset = '0;
      end
      return res;
   endfunction

   // Valid is lowered only when a gap follows, so back-to-back requests keep
   // it high without a second assignment in the same step.
   task automatic send_request(input logic mode, input int unsigned bytes,
                               input int unsigned offs);
      ffha_pkg::req_type r;
      ffha_pkg::rsp_type want;
      r.mode = mode;
      r.request_size = bytes[ffha_pkg::FIELD_W-1:0];
      r.payload_offset = offs[ffha_pkg::FIELD_W-1:0];
      if (idle_on && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      want = heap_apply(r);
      expected_rsp.push_back(want);
      if (want.status == ffha_pkg::STAT_OK) begin
         if (mode == ffha_pkg::MODE_ALLOC) begin
            live_offsets.push_back(32'(want.block_offset));
         end else begin
            for (int i = 0; i < live_offsets.size(); i++) begin
               if (live_offsets[i] == 32'(r.payload_offset)) begin
                  live_offsets.delete(i);
                  break;
               end
            end
            freed_offsets.push_back(32'(r.payload_offset));
            if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
         end
      end
   endtask

   always @(posedge clock) begin : response_check
      ffha_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual status %0d offset %0d",
                     $time, rsp_data.status, rsp_data.block_offset);
            mismatch_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.block_offset !== want.block_offset) begin
               $display("%0t: block_offset mismatch: expected %0d actual %0d",
                        $time, want.block_offset, rsp_data.block_offset);
               mismatch_count++;
            end
         end
      end
      rsp_ready <= !(idle_on && $urandom_range(99) < 30);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d responses outstanding", $time, expected_rsp.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Zero and oversized requests, plus requests that would leave a spare of a
   // header or less in the only block, which therefore find no space.
   task automatic check_bad_sizes();
      send_request(ffha_pkg::MODE_ALLOC, 0, 0);
      send_request(ffha_pkg::MODE_ALLOC, 4088, 4095);
      send_request(ffha_pkg::MODE_ALLOC, 4095, 0);
      send_request(ffha_pkg::MODE_ALLOC, 4087, 0);
      send_request(ffha_pkg::MODE_ALLOC, 4080, 4095);
   endtask

   task automatic check_bad_pointers();
      send_request(ffha_pkg::MODE_FREE, 4095, 0);
      send_request(ffha_pkg::MODE_FREE, 0, 4095);
      send_request(ffha_pkg::MODE_FREE, 0, 9);
      send_request(ffha_pkg::MODE_FREE, 4095, 8);
   endtask

   task automatic check_exact_fit();
      send_request(ffha_pkg::MODE_ALLOC, 16, 0);
      send_request(ffha_pkg::MODE_ALLOC, 16, 0);
      send_request(ffha_pkg::MODE_FREE, 0, 8);
      send_request(ffha_pkg::MODE_FREE, 0, 8);
      send_request(ffha_pkg::MODE_ALLOC, 16, 0);
      send_request(ffha_pkg::MODE_FREE, 0, 8);
      send_request(ffha_pkg::MODE_FREE, 0, 32);
   endtask

   // Frees the first block, then the third, then the middle one, which has a
   // free block on both sides.
   task automatic check_coalescing();
      send_request(ffha_pkg::MODE_ALLOC, 100, 0);
      send_request(ffha_pkg::MODE_ALLOC, 100, 0);
      send_request(ffha_pkg::MODE_ALLOC, 100, 0);
      send_request(ffha_pkg::MODE_FREE, 0, 8);
      send_request(ffha_pkg::MODE_FREE, 0, 224);
      send_request(ffha_pkg::MODE_FREE, 0, 116);
   endtask

   // The second block ends exactly at the arena end and has no next block.
   task automatic check_arena_edge();
      send_request(ffha_pkg::MODE_ALLOC, 4079, 0);
      send_request(ffha_pkg::MODE_ALLOC, 1, 0);
      send_request(ffha_pkg::MODE_FREE, 4095, 4095);
      send_request(ffha_pkg::MODE_FREE, 4095, 8);
   endtask

   task automatic check_random_traffic(input int count);
      int unsigned pick;
      int unsigned bytes;
      int unsigned offs;
      int unsigned free_pct;
      int unsigned band;
      repeat (count) begin
         pick = $urandom_range(99);
         bytes = $urandom_range(4095);
         offs = $urandom_range(4095);
         free_pct = (live_offsets.size() > 40) ? 60 : 35;
         if (pick < 6) begin
            send_request(ffha_pkg::MODE_FREE, bytes, offs);
         end else if (pick < 9 && freed_offsets.size() != 0) begin
            send_request(ffha_pkg::MODE_FREE, bytes,
                         freed_offsets[$urandom_range(freed_offsets.size() - 1)]);
         end else if (pick < 11) begin
            send_request(ffha_pkg::MODE_ALLOC,
                         $urandom_range(1) ? 0 : $urandom_range(4095, 4088), offs);
         end else if (live_offsets.size() != 0 && $urandom_range(99) < free_pct) begin
            send_request(ffha_pkg::MODE_FREE, bytes,
                         live_offsets[$urandom_range(live_offsets.size() - 1)]);
         end else begin
            band = $urandom_range(99);
            if (band < 60)      bytes = $urandom_range(16, 1);
            else if (band < 88) bytes = $urandom_range(128, 17);
            else if (band < 98) bytes = $urandom_range(1024, 129);
            else                bytes = $urandom_range(4087, 1025);
            send_request(ffha_pkg::MODE_ALLOC, bytes, offs);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      for (int i = 0; i < ffha_pkg::ARENA_BYTES; i++) begin
         blk_size[i] = '0;
         blk_used[i] = 1'b0;
      end
      blk_size[0] = ffha_pkg::SIZE_W'(ffha_pkg::ARENA_BYTES);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      check_bad_sizes();
      check_bad_pointers();
      check_exact_fit();
      check_coalescing();
      check_arena_edge();
      check_random_traffic(450);
      idle_on <= 1'b0;
      check_random_traffic(250);
      idle_on <= 1'b1;
      check_random_traffic(445);

      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
